FILE: rtl/thp_sensor_compensation_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sensor compensation unit
// Each macro expands to a clocked concurrent check, or to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef THP_SENSOR_COMPENSATION_UNIT_DEFINES_SVH
`define THP_SENSOR_COMPENSATION_UNIT_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define THP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("thp implication check failed");
// Next-cycle implication, checked out of reset.
`define THP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("thp next-cycle check failed");
`else
`define THP_ASSERT_IMP(label, ante, cons)
`define THP_ASSERT_NXT(label, ante, cons)
`endif
`endif

FILE: rtl/thp_pkg.sv
// ----------------------------------------------------------------------------
// thp_pkg
// Shared types, constants and arithmetic helpers of the compensation unit.
// ----------------------------------------------------------------------------
package thp_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_TEMP_CALIB    = 3'd0,
    CFG_PRESS_CALIB_A = 3'd1,
    CFG_PRESS_CALIB_B = 3'd2,
    CFG_PRESS_CALIB_C = 3'd3,
    CFG_HUM_CALIB     = 3'd4
  } cfg_idx_t;

  localparam logic [19:0] SKIP_CODE   = 20'h80000;
  localparam logic [33:0] P_OFFSET    = 34'd128000;
  localparam logic [63:0] P_FULLSCALE = 64'd1048576;
  localparam logic [16:0] P_SCALE     = 17'd3125;
  localparam logic [31:0] H_OFFSET    = 32'd76800;
  localparam logic [31:0] H_CLAMP     = 32'd419430400;
  localparam logic [31:0] H_ROUND     = 32'd16384;
  localparam logic [31:0] H_BIAS      = 32'd2097152;
  localparam logic [31:0] H_ROUND2    = 32'd8192;

  // Depth of the restoring divider, one quotient bit per stage.
  localparam int DIV_STAGES = 64;

  // Values that travel alongside the divider.
  typedef struct packed {
    logic [15:0] temp;
    logic [16:0] hum;
    logic        skip;
    logic        zero;
    logic        neg;
  } side_t;

  function automatic logic [31:0] asr32(logic [31:0] x, int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int unsigned n);
    return 64'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] mul32(logic [31:0] a, logic [31:0] b);
    return a * b;
  endfunction

  function automatic logic [63:0] sext16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // Low 64 bits of a 64-bit word times a signed 17-bit factor, in two halves.
  function automatic logic [63:0] mulw64_16(logic [63:0] a, logic signed [16:0] b);
    logic signed [49:0] lo;
    logic [31:0]        hi;
    lo = $signed({1'b0, a[31:0]}) * b;
    hi = a[63:32] * {{15{b[16]}}, b};
    return {{14{lo[49]}}, lo} + {hi, 32'h0};
  endfunction

endpackage

FILE: rtl/thp_if.sv
// ----------------------------------------------------------------------------
// thp_in_if / thp_out_if
// Valid/ready request channels for raw triplets and compensated results.
// ----------------------------------------------------------------------------
interface thp_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_pressure;
  logic [19:0] raw_temperature;
  logic [15:0] raw_humidity;

  modport source (output valid, raw_pressure, raw_temperature, raw_humidity, input ready);
  modport sink   (input valid, raw_pressure, raw_temperature, raw_humidity, output ready);
endinterface

interface thp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature_centi;
  logic [31:0]        pressure_q24_8;
  logic [16:0]        humidity_q22_10;
  logic               skipped;

  modport source (output valid, temperature_centi, pressure_q24_8, humidity_q22_10,
                  skipped, input ready);
  modport sink   (input valid, temperature_centi, pressure_q24_8, humidity_q22_10,
                  skipped, output ready);
endinterface

FILE: rtl/thp_div.sv
// ----------------------------------------------------------------------------
// thp_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// side band that travels in step with the operands.
// ----------------------------------------------------------------------------
module thp_div
  import thp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] in_num,
  input  logic [63:0] in_den,
  input  side_t       in_side,
  output logic        out_valid,
  output logic [63:0] out_quot,
  output side_t       out_side
);

  logic [DIV_STAGES-1:0] vld_r;
  logic [63:0]           rem_r  [DIV_STAGES];
  logic [63:0]           num_r  [DIV_STAGES];
  logic [63:0]           den_r  [DIV_STAGES];
  logic [63:0]           quot_r [DIV_STAGES];
  side_t                 side_r [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic        vld_i;
    logic [63:0] rem_i, num_i, den_i, quot_i;
    side_t       side_i;
    logic [64:0] trial;
    logic [64:0] diff;
    logic        ge;

    // Stage operands come from the inputs or from the stage before.
    if (k == 0) begin : g_first
      assign vld_i  = in_valid;
      assign rem_i  = 64'd0;
      assign num_i  = in_num;
      assign den_i  = in_den;
      assign quot_i = 64'd0;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign num_i  = num_r[k-1];
      assign den_i  = den_r[k-1];
      assign quot_i = quot_r[k-1];
      assign side_i = side_r[k-1];
    end

    // Bring down one numerator bit and try the subtraction.
    assign trial = {rem_i, num_i[63]};
    assign diff  = trial - {1'b0, den_i};
    assign ge    = (trial >= {1'b0, den_i});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[63:0] : trial[63:0];
        num_r[k]  <= {num_i[62:0], 1'b0};
        den_r[k]  <= den_i;
        quot_r[k] <= {quot_i[62:0], ge};
        side_r[k] <= side_i;
      end
    end
  end

  assign out_valid = vld_r[DIV_STAGES-1];
  assign out_quot  = quot_r[DIV_STAGES-1];
  assign out_side  = side_r[DIV_STAGES-1];

endmodule

FILE: rtl/thp_sensor_compensation_unit.sv
// ----------------------------------------------------------------------------
// thp_sensor_compensation_unit
// Integer compensation of raw temperature, pressure and humidity readings.
// The 64-stage pressure divider and the multiply stages around it lie
// between request acceptance and result. Throughput: one request per
// cycle while the skid register, which holds a stalled result, is empty.
// Reset clears all valid bits and the calibration registers to zero.
// ----------------------------------------------------------------------------
`include "thp_sensor_compensation_unit_defines.svh"

module thp_sensor_compensation_unit
  import thp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  thp_in_if.sink           in_ch,
  thp_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [63:0]      cfg_wdata
);

  // Calibration registers.
  logic [47:0] temp_calib_r;
  logic [63:0] press_a_r, press_b_r, hum_calib_r;
  logic [15:0] press_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_calib_r <= '0;
      press_a_r    <= '0;
      press_b_r    <= '0;
      press_c_r    <= '0;
      hum_calib_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEMP_CALIB:    temp_calib_r <= cfg_wdata[47:0];
        CFG_PRESS_CALIB_A: press_a_r    <= cfg_wdata;
        CFG_PRESS_CALIB_B: press_b_r    <= cfg_wdata;
        CFG_PRESS_CALIB_C: press_c_r    <= cfg_wdata[15:0];
        CFG_HUM_CALIB:     hum_calib_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Coefficient fields.
  logic [31:0] t1, t2, t3;
  logic [15:0] p1;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;

  assign t1 = {16'd0, temp_calib_r[15:0]};
  assign t2 = {{16{temp_calib_r[31]}}, temp_calib_r[31:16]};
  assign t3 = {{16{temp_calib_r[47]}}, temp_calib_r[47:32]};
  assign p1 = press_a_r[15:0];
  assign p2 = press_a_r[31:16];
  assign p3 = press_a_r[47:32];
  assign p4 = press_a_r[63:48];
  assign p5 = press_b_r[15:0];
  assign p6 = press_b_r[31:16];
  assign p7 = press_b_r[47:32];
  assign p8 = press_b_r[63:48];
  assign p9 = press_c_r;
  assign h1 = {24'd0, hum_calib_r[7:0]};
  assign h2 = {{16{hum_calib_r[23]}}, hum_calib_r[23:8]};
  assign h3 = {24'd0, hum_calib_r[31:24]};
  assign h4 = {{20{hum_calib_r[43]}}, hum_calib_r[43:32]};
  assign h5 = {{20{hum_calib_r[55]}}, hum_calib_r[55:44]};
  assign h6 = {{24{hum_calib_r[63]}}, hum_calib_r[63:56]};

  // The whole pipe advances while the skid register is empty.
  logic en;
  logic skid_v_r;
  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  logic [12:1] vld_r;
  logic [12:1] skip_r;
  logic [19:0] up_r [1:8];
  logic [15:0] uh_r [1:4];
  logic [15:0] temp_r [5:12];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[11:1], in_ch.valid};
    end
  end

  // Fine temperature, stages 1 to 4.
  logic [31:0] s1_a_r, s1_d_r, s2_m1_r, s2_dd_r, s3_v1_r, s3_m3_r, s4_tf_r;
  logic [31:0] ut32;
  assign ut32 = {12'd0, in_ch.raw_temperature};

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a_r  <= (ut32 >> 3) - (t1 << 1);
      s1_d_r  <= (ut32 >> 4) - t1;
      s2_m1_r <= mul32(s1_a_r, t2);
      s2_dd_r <= mul32(s1_d_r, s1_d_r);
      s3_v1_r <= asr32(s2_m1_r, 11);
      s3_m3_r <= mul32(asr32(s2_dd_r, 12), t3);
      s4_tf_r <= s3_v1_r + asr32(s3_m3_r, 14);
    end
  end

  // Temperature output, stage 5.
  logic signed [35:0] tf36, tt, tsh;
  logic [15:0] temp_sat;
  assign tf36 = {{4{s4_tf_r[31]}}, s4_tf_r};
  assign tt   = (tf36 <<< 2) + tf36 + 36'sd128;
  assign tsh  = tt >>> 8;
  always_comb begin
    if (tsh > 36'sd32767) begin
      temp_sat = 16'h7fff;
    end else if (tsh < -36'sd32768) begin
      temp_sat = 16'h8000;
    end else begin
      temp_sat = tsh[15:0];
    end
  end

  // Carried fields.
  always_ff @(posedge clk) begin
    if (en) begin
      skip_r <= {skip_r[11:1], in_ch.raw_temperature == SKIP_CODE};
      up_r[1] <= in_ch.raw_pressure;
      for (int i = 2; i <= 8; i++) up_r[i] <= up_r[i-1];
      uh_r[1] <= in_ch.raw_humidity;
      for (int i = 2; i <= 4; i++) uh_r[i] <= uh_r[i-1];
      temp_r[5] <= temp_sat;
      for (int i = 6; i <= 12; i++) temp_r[i] <= temp_r[i-1];
    end
  end

  // Pressure path up to the divider, stages 5 to 12.
  logic signed [33:0] s5_pv1_r;
  logic signed [67:0] sq_full;
  logic [63:0]        s6_sq_r;
  logic signed [49:0] s6_m5_r, s6_m2_r, s7_m5_r, s7_m2_r;
  logic [63:0]        s7_a6_r, s7_a3_r, s8_v2_r, s8_v1_r, s9_x_r, s9_nb_r;
  logic [63:0]        s10_y_r, s10_num_r, s11_den_r, s11_num_r;
  logic [63:0]        s12_an_r, s12_ad_r;
  logic               s12_neg_r, s12_zero_r;

  assign sq_full = s5_pv1_r * s5_pv1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_pv1_r   <= $signed({{2{s4_tf_r[31]}}, s4_tf_r}) - $signed(P_OFFSET);
      s6_sq_r    <= sq_full[63:0];
      s6_m5_r    <= s5_pv1_r * p5;
      s6_m2_r    <= s5_pv1_r * p2;
      s7_a6_r    <= mulw64_16(s6_sq_r, {p6[15], p6});
      s7_a3_r    <= mulw64_16(s6_sq_r, {p3[15], p3});
      s7_m5_r    <= s6_m5_r;
      s7_m2_r    <= s6_m2_r;
      s8_v2_r    <= s7_a6_r + ({{14{s7_m5_r[49]}}, s7_m5_r} << 17) + (sext16(p4) << 35);
      s8_v1_r    <= asr64(s7_a3_r, 8) + ({{14{s7_m2_r[49]}}, s7_m2_r} << 12);
      s9_x_r     <= s8_v1_r + (64'd1 << 47);
      s9_nb_r    <= ((P_FULLSCALE - {44'd0, up_r[8]}) << 31) - s8_v2_r;
      s10_y_r    <= mulw64_16(s9_x_r, {1'b0, p1});
      s10_num_r  <= mulw64_16(s9_nb_r, P_SCALE);
      s11_den_r  <= asr64(s10_y_r, 33);
      s11_num_r  <= s10_num_r;
      s12_an_r   <= s11_num_r[63] ? 64'd0 - s11_num_r : s11_num_r;
      s12_ad_r   <= s11_den_r[63] ? 64'd0 - s11_den_r : s11_den_r;
      s12_neg_r  <= s11_num_r[63] ^ s11_den_r[63];
      s12_zero_r <= (s11_den_r == 64'd0);
    end
  end

  // Humidity path, stages 5 to 12.
  logic [31:0] s5_hv_r, s5_xa_r, s6_mh5_r, s6_my_r, s6_mz_r, s6_xa_r;
  logic [31:0] s7_x_r, s7_wy_r, s8_wm_r, s8_x_r, s9_vv_r, s10_vv_r, s10_qq_r;
  logic [31:0] s11_vv_r, s11_qqh_r;
  logic [16:0] s12_hum_r;
  logic [31:0] hy, hz, hw, hw2, hq, hvf, hcl;

  assign hy  = asr32(s6_my_r, 10);
  assign hz  = asr32(s6_mz_r, 11) + 32'd32768;
  assign hw  = asr32(s7_wy_r, 10) + H_BIAS;
  assign hw2 = asr32(s8_wm_r + H_ROUND2, 14);
  assign hq  = asr32(s9_vv_r, 15);
  assign hvf = s11_vv_r - asr32(s11_qqh_r, 4);

  // Clamp to the valid percentage range before the final shift.
  always_comb begin
    if (hvf[31]) begin
      hcl = 32'd0;
    end else if (hvf > H_CLAMP) begin
      hcl = H_CLAMP;
    end else begin
      hcl = hvf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_hv_r   <= s4_tf_r - H_OFFSET;
      s5_xa_r   <= ({16'd0, uh_r[4]} << 14) - (h4 << 20) + H_ROUND;
      s6_mh5_r  <= mul32(h5, s5_hv_r);
      s6_my_r   <= mul32(s5_hv_r, h6);
      s6_mz_r   <= mul32(s5_hv_r, h3);
      s6_xa_r   <= s5_xa_r;
      s7_x_r    <= asr32(s6_xa_r - s6_mh5_r, 15);
      s7_wy_r   <= mul32(hy, hz);
      s8_wm_r   <= mul32(hw, h2);
      s8_x_r    <= s7_x_r;
      s9_vv_r   <= mul32(s8_x_r, hw2);
      s10_vv_r  <= s9_vv_r;
      s10_qq_r  <= mul32(hq, hq);
      s11_vv_r  <= s10_vv_r;
      s11_qqh_r <= mul32(asr32(s10_qq_r, 7), h1);
      s12_hum_r <= hcl[28:12];
    end
  end

  // Divider.
  side_t       div_side_in, div_side_out;
  logic        div_vld;
  logic [63:0] div_quot;

  assign div_side_in = '{temp: temp_r[12], hum: s12_hum_r, skip: skip_r[12],
                         zero: s12_zero_r, neg: s12_neg_r};

  thp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vld_r[12]),
    .in_num    (s12_an_r),
    .in_den    (s12_ad_r),
    .in_side   (div_side_in),
    .out_valid (div_vld),
    .out_quot  (div_quot),
    .out_side  (div_side_out)
  );

  // Pressure after the divider, stages 77 to 82.
  logic [5:0]  post_vld_r;
  side_t       post_side_r [0:4];
  logic [63:0] e0_p_r, e1_p_r, e1_a9_r, e1_m8_r, e1_q13_r;
  logic [63:0] e2_p_r, e2_m8_r, e2_ll_r, e3_p_r, e3_m8_r, e3_prod_r, e4_s_r;
  logic [31:0] e2_lh_r, e2_hl_r;
  logic [63:0] pres64;
  logic signed [15:0] o_temp_r;
  logic [31:0] o_pres_r;
  logic [16:0] o_hum_r;
  logic        o_skip_r;

  assign pres64 = asr64(e4_s_r, 8) + (sext16(p7) << 4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      post_vld_r <= '0;
    end else if (en) begin
      post_vld_r <= {post_vld_r[4:0], div_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      post_side_r[0] <= div_side_out;
      for (int i = 1; i <= 4; i++) post_side_r[i] <= post_side_r[i-1];
      e0_p_r    <= div_side_out.neg ? 64'd0 - div_quot : div_quot;
      e1_q13_r  <= asr64(e0_p_r, 13);
      e1_a9_r   <= mulw64_16(asr64(e0_p_r, 13), {p9[15], p9});
      e1_m8_r   <= mulw64_16(e0_p_r, {p8[15], p8});
      e1_p_r    <= e0_p_r;
      e2_ll_r   <= e1_a9_r[31:0] * e1_q13_r[31:0];
      e2_lh_r   <= mul32(e1_a9_r[31:0], e1_q13_r[63:32]);
      e2_hl_r   <= mul32(e1_a9_r[63:32], e1_q13_r[31:0]);
      e2_m8_r   <= e1_m8_r;
      e2_p_r    <= e1_p_r;
      e3_prod_r <= e2_ll_r + {e2_lh_r + e2_hl_r, 32'h0};
      e3_m8_r   <= e2_m8_r;
      e3_p_r    <= e2_p_r;
      e4_s_r    <= e3_p_r + asr64(e3_prod_r, 25) + asr64(e3_m8_r, 19);
      // Skipped measurements and a zero divisor force their fields to zero.
      if (post_side_r[4].skip) begin
        o_temp_r <= '0;
        o_pres_r <= '0;
        o_hum_r  <= '0;
        o_skip_r <= 1'b1;
      end else begin
        o_temp_r <= post_side_r[4].temp;
        o_pres_r <= post_side_r[4].zero ? 32'd0 : pres64[31:0];
        o_hum_r  <= post_side_r[4].hum;
        o_skip_r <= 1'b0;
      end
    end
  end

  // Skid register: catches the last stage when the sink stalls.
  logic               o_vld;
  logic signed [15:0] skid_temp_r;
  logic [31:0]        skid_pres_r;
  logic [16:0]        skid_hum_r;
  logic               skid_skip_r;

  assign o_vld = post_vld_r[5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ch.ready) skid_v_r <= 1'b0;
    end else if (o_vld && !out_ch.ready) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r && o_vld && !out_ch.ready) begin
      skid_temp_r <= o_temp_r;
      skid_pres_r <= o_pres_r;
      skid_hum_r  <= o_hum_r;
      skid_skip_r <= o_skip_r;
    end
  end

  assign out_ch.valid             = skid_v_r || o_vld;
  assign out_ch.temperature_centi = skid_v_r ? skid_temp_r : o_temp_r;
  assign out_ch.pressure_q24_8    = skid_v_r ? skid_pres_r : o_pres_r;
  assign out_ch.humidity_q22_10   = skid_v_r ? skid_hum_r  : o_hum_r;
  assign out_ch.skipped           = skid_v_r ? skid_skip_r : o_skip_r;

  // Checks.
  `THP_ASSERT_NXT(a_skid_capture, !skid_v_r && o_vld && !out_ch.ready, skid_v_r)
  `THP_ASSERT_IMP(a_skip_pres, out_ch.valid && out_ch.skipped, out_ch.pressure_q24_8 == 32'd0)
  `THP_ASSERT_IMP(a_skip_temp, out_ch.valid && out_ch.skipped, out_ch.temperature_centi == 16'sd0)
  `THP_ASSERT_IMP(a_skip_hum, out_ch.valid && out_ch.skipped, out_ch.humidity_q22_10 == 17'd0)
  `THP_ASSERT_IMP(a_hum_range, out_ch.valid, out_ch.humidity_q22_10 <= 17'd102400)
  `THP_ASSERT_NXT(a_skid_hold, skid_v_r && !out_ch.ready, skid_v_r && $stable(skid_pres_r))

endmodule
